// ===== rtl/bed_pkg.sv =====
// Package for the backslash escape decoder: command record, mode codes,
// character constants and hex/escape helper functions. No dependencies.
package bed_pkg;

    localparam int QueueDepth = 4;
    localparam int MaxBytes   = 3;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChCaret     = 8'h5E;
    localparam logic [7:0] ChX         = 8'h78;
    localparam logic [7:0] ChQuestion  = 8'h3F;
    localparam logic [7:0] CtrlMask    = 8'h1F;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BSL    = 3'd1,
        MODE_CARET  = 3'd2,
        MODE_HEX0   = 3'd3,
        MODE_HEX1   = 3'd4
    } t_mode;

    // One decoded input item: up to three bytes, lowest index first.
    typedef struct packed {
        logic [1:0]          count;
        logic [2:0][7:0]     bytes;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic [7:0] value;
    } t_esc;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    function automatic t_esc esc_map(input logic [7:0] c);
        t_esc r;
        r.valid = 1'b1;
        case (c)
            8'h65:       r.value = 8'h1B;   // e
            8'h73:       r.value = 8'h20;   // s
            8'h62:       r.value = 8'h08;   // b
            8'h6E:       r.value = 8'h0A;   // n
            8'h72:       r.value = 8'h0D;   // r
            8'h74:       r.value = 8'h09;   // t
            8'h61:       r.value = 8'h07;   // a
            ChBackslash: r.value = 8'h5C;
            ChCaret:     r.value = 8'h5E;
            default: begin
                r.valid = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bed_front.sv =====
// Front end: holds the escape mode, classifies each accepted character and
// builds the command record of decoded bytes. Depends on bed_pkg.
module bed_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_char,
    input  logic         i_final,
    output logic         o_push,
    output bed_pkg::t_cmd o_cmd
);
    import bed_pkg::*;

    t_mode      r_mode, n_mode, w_mode_mid, w_plain_mode;
    logic [7:0] r_held, n_held;
    logic       w_hex;

    assign w_hex = is_hex(i_char);

    always_comb begin
        if (i_char == ChBackslash) begin
            w_plain_mode = MODE_BSL;
        end else if (i_char == ChCaret) begin
            w_plain_mode = MODE_CARET;
        end else begin
            w_plain_mode = MODE_NORMAL;
        end
    end

    // next state
    always_comb begin
        w_mode_mid = MODE_NORMAL;
        n_held     = r_held;
        case (r_mode)
            MODE_BSL: begin
                w_mode_mid = (i_char == ChX) ? MODE_HEX0 : MODE_NORMAL;
            end
            MODE_CARET: begin
                w_mode_mid = MODE_NORMAL;
            end
            MODE_HEX0: begin
                if (w_hex) begin
                    n_held     = i_char;
                    w_mode_mid = MODE_HEX1;
                end else begin
                    w_mode_mid = w_plain_mode;
                end
            end
            MODE_HEX1: begin
                w_mode_mid = w_hex ? MODE_NORMAL : w_plain_mode;
            end
            default: begin
                w_mode_mid = w_plain_mode;
            end
        endcase
        n_mode = i_final ? MODE_NORMAL : w_mode_mid;
    end

    // outputs
    always_comb begin
        t_esc       esc;
        logic [1:0] cnt;
        logic       plain_emit;
        cnt        = 2'd0;
        esc        = esc_map(i_char);
        plain_emit = (w_plain_mode == MODE_NORMAL);
        o_cmd      = '0;
        case (r_mode)
            MODE_BSL: begin
                if (esc.valid) begin
                    o_cmd.bytes[cnt] = esc.value;
                    cnt = cnt + 2'd1;
                end
            end
            MODE_CARET: begin
                o_cmd.bytes[cnt] = i_char & CtrlMask;
                cnt = cnt + 2'd1;
            end
            MODE_HEX0: begin
                if (!w_hex) begin
                    o_cmd.bytes[cnt] = ChQuestion;
                    cnt = cnt + 2'd1;
                    if (plain_emit) begin
                        o_cmd.bytes[cnt] = i_char;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            MODE_HEX1: begin
                if (w_hex) begin
                    o_cmd.bytes[cnt] = {hex_val(r_held), hex_val(i_char)};
                    cnt = cnt + 2'd1;
                end else begin
                    o_cmd.bytes[cnt] = ChQuestion;
                    cnt = cnt + 2'd1;
                    o_cmd.bytes[cnt] = r_held;
                    cnt = cnt + 2'd1;
                    if (plain_emit) begin
                        o_cmd.bytes[cnt] = i_char;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default: begin
                if (plain_emit) begin
                    o_cmd.bytes[cnt] = i_char;
                    cnt = cnt + 2'd1;
                end
            end
        endcase
        if (i_final && w_mode_mid == MODE_HEX0) begin
            o_cmd.bytes[cnt] = ChQuestion;
            cnt = cnt + 2'd1;
        end else if (i_final && w_mode_mid == MODE_HEX1) begin
            o_cmd.bytes[cnt] = ChQuestion;
            cnt = cnt + 2'd1;
            o_cmd.bytes[cnt] = n_held;
            cnt = cnt + 2'd1;
        end
        o_cmd.count = cnt;
        o_push      = i_accept && (cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_held <= 8'h00;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

    property p_final_clears_mode;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_accept && i_final) |=> (r_mode == MODE_NORMAL);
    endproperty
    a_final_clears_mode: assert property (p_final_clears_mode)
        else $error("mode not normal after final beat");

endmodule

// ===== rtl/bed_queue.sv =====
// Short queue of command records between front and back end.
// Depends on bed_pkg.
module bed_queue #(
    parameter int DEPTH = bed_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bed_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bed_pkg::t_cmd o_head
);
    import bed_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count over depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow queue");

endmodule

// ===== rtl/bed_back.sv =====
// Back end: walks the bytes of the head record one beat at a time and marks
// the last byte of each record. Depends on bed_pkg.
module bed_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  bed_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // [7:0] out_byte
    output logic          m_axis_tlast    // run_last
);
    import bed_pkg::*;

    logic [1:0] r_idx;
    logic       w_last;

    assign w_last        = (r_idx == i_head.count - 2'd1);
    assign m_axis_tvalid = !i_empty;
    assign m_axis_tdata  = i_head.bytes[r_idx];
    assign m_axis_tlast  = w_last;
    assign o_pop         = m_axis_tvalid && m_axis_tready && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/backslash_escape_decoder_core.sv =====
// Backslash escape decoder top level: front end, record queue, back end.
// Depends on bed_pkg, bed_front, bed_queue, bed_back.
//
// Input stream: one text character per beat on s_axis_tdata, s_axis_tlast
// marks the final character and flushes a pending hex escape.
// Output stream: decoded bytes on m_axis_tdata; m_axis_tlast is set on the
// last byte produced by one input beat. Input beats that decode to nothing
// (lone backslash/caret, unknown escape, first hex digit) give no beat.
// Each input beat's record is written into the record queue register, and
// its first byte is offered once that record is at the queue head.
// Throughput: one input beat per cycle while each yields at most one byte
// and m_axis_tready stays high; a beat yielding up to 3 bytes is sent one
// byte per cycle from the queue head while m_axis_tready is high.
// s_axis_tready drops only while the QUEUE_DEPTH-entry record queue is full,
// so an output stall is absorbed for that many records before input stalls.
// Reset (i_rst_n low, synchronous) returns to plain text mode and empties
// the queue.
module backslash_escape_decoder_core #(
    parameter int QUEUE_DEPTH = bed_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_char
    input  logic       s_axis_tlast,   // final_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // run_last
);
    import bed_pkg::*;

    logic w_accept, w_push, w_pop, w_full, w_empty;
    t_cmd w_cmd, w_head;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    bed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    bed_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
